// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file rrwl_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/rrwl_pkg.sv =====
// ----------------------------------------------------------------------------
// rrwl_pkg
// Types and fixed widths for the recursive reader/writer lock manager.
// ----------------------------------------------------------------------------
package rrwl_pkg;

  localparam int REQ_W       = 4;
  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 2;
  localparam int HOLD_W      = 8;
  localparam int TOTAL_W     = 12;
  localparam int DEPTH_EXT_W = 16;

  localparam logic [TOTAL_W-1:0]     TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam logic [DEPTH_EXT_W-1:0] HOLD_SAT  = DEPTH_EXT_W'({HOLD_W{1'b1}});

  typedef enum logic [CMD_W-1:0] {
    CMD_RD_ACQ = 3'd0,
    CMD_RD_REL = 3'd1,
    CMD_WR_ACQ = 3'd2,
    CMD_WR_REL = 3'd3,
    CMD_QUERY  = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_BUSY     = 2'd1,
    ST_MISUSE   = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  // State update strobes from the decision logic.
  typedef struct packed {
    logic rd_inc;
    logic rd_dec;
    logic tot_dec;
    logic wr_set;
    logic wr_inc;
    logic wr_dec;
    logic wr_clear;
  } upd_t;

endpackage

// ===== rtl/rrwl_decide.sv =====
// ----------------------------------------------------------------------------
// rrwl_decide
// Grant/refuse decision for one lock request and the state update strobes.
// ----------------------------------------------------------------------------
module rrwl_decide #(
  parameter int DEPTH_W   = 8,
  parameter int MAX_DEPTH = 255
) (
  input  logic [rrwl_pkg::CMD_W-1:0]   cmd,
  input  logic                         req_ok,
  input  logic [DEPTH_W-1:0]           rd_depth,
  input  logic [rrwl_pkg::TOTAL_W-1:0] total,
  input  logic                         wr_present,
  input  logic                         is_wr,
  input  logic [DEPTH_W-1:0]           wr_depth,
  output rrwl_pkg::status_t            status,
  output rrwl_pkg::upd_t               upd
);
  import rrwl_pkg::*;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);
  localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);

  always_comb begin
    status = ST_OK;
    upd    = '0;
    if (!req_ok) begin
      status = ST_MISUSE;
    end else begin
      unique case (cmd_t'(cmd))
        CMD_RD_ACQ: begin
          priority if (wr_present && !is_wr) begin
            status = ST_BUSY;
          end else if (rd_depth >= DEPTH_MAX || total >= TOTAL_MAX) begin
            status = ST_OVERFLOW;
          end else begin
            upd.rd_inc = 1'b1;
          end
        end
        CMD_RD_REL: begin
          if (rd_depth == '0) begin
            status = ST_MISUSE;
          end else begin
            upd.rd_dec  = 1'b1;
            upd.tot_dec = (total != '0);
          end
        end
        CMD_WR_ACQ: begin
          // read holder asking for write is misuse, even for the writer
          priority if (rd_depth != '0) begin
            status = ST_MISUSE;
          end else if (is_wr) begin
            if (wr_depth >= DEPTH_MAX) begin
              status = ST_OVERFLOW;
            end else begin
              upd.wr_inc = 1'b1;
            end
          end else if (total == '0 && !wr_present) begin
            upd.wr_set = 1'b1;
          end else begin
            status = ST_BUSY;
          end
        end
        CMD_WR_REL: begin
          priority if (!is_wr) begin
            status = ST_MISUSE;
          end else if (wr_depth <= DEPTH_ONE) begin
            upd.wr_clear = 1'b1;
          end else begin
            upd.wr_dec = 1'b1;
          end
        end
        CMD_QUERY: begin
          status = ST_OK;
        end
        default: begin
          status = ST_MISUSE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/recursive_reader_writer_lock.sv =====
// ----------------------------------------------------------------------------
// recursive_reader_writer_lock: one request per cycle while the result is taken;
// a request passes the input register, then the result register.
// Lock state updates in the same cycle the result register loads.
// A stalled result holds the input register; input stalls once both are full and the result is stalled.
// Synchronous active-low reset: all holds cleared, no writer, outputs idle.
// ----------------------------------------------------------------------------
module recursive_reader_writer_lock #(
  parameter int NUM_REQUESTERS = 16,
  parameter int MAX_DEPTH      = 255
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rrwl_pkg::CMD_W-1:0]    in_cmd,
  input  logic [rrwl_pkg::REQ_W-1:0]    in_requester,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rrwl_pkg::STATUS_W-1:0] out_status,
  output logic                          out_holds_read,
  output logic                          out_holds_write,
  output logic [rrwl_pkg::HOLD_W-1:0]   out_hold_depth
);
  import rrwl_pkg::*;

  // only requesters the port can address get storage
  localparam int STORE_N = (NUM_REQUESTERS < (1 << REQ_W)) ? NUM_REQUESTERS : (1 << REQ_W);
  localparam int IDX_W   = $clog2(STORE_N);
  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

  // input stage
  logic             s1_valid_r;
  logic [CMD_W-1:0] s1_cmd_r;
  logic [REQ_W-1:0] s1_req_r;

  // result stage
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic                out_hr_r;
  logic                out_hw_r;
  logic [HOLD_W-1:0]   out_depth_r;

  // lock state
  logic [DEPTH_W-1:0] rd_depth_r [STORE_N];
  logic [TOTAL_W-1:0] total_r;
  logic               wr_present_r;
  logic [REQ_W-1:0]   wr_owner_r;
  logic [DEPTH_W-1:0] wr_depth_r;

  logic [TOTAL_W-1:0] total_nxt;
  logic               wr_present_nxt;
  logic [REQ_W-1:0]   wr_owner_nxt;
  logic [DEPTH_W-1:0] wr_depth_nxt;
  logic [DEPTH_W-1:0] rd_nxt;

  logic                   advance;
  logic                   fire;
  logic                   req_ok;
  logic [IDX_W-1:0]       idx;
  logic [DEPTH_W-1:0]     rd_cur;
  logic                   is_wr;
  status_t                status;
  upd_t                   upd;
  logic                   hr_new;
  logic                   hw_new;
  logic [DEPTH_EXT_W-1:0] depth_ext;
  logic [HOLD_W-1:0]      hold_new;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;
  assign fire     = s1_valid_r && advance;

  assign req_ok = (int'(s1_req_r) < NUM_REQUESTERS);
  assign idx    = s1_req_r[IDX_W-1:0];
  assign rd_cur = rd_depth_r[idx];
  assign is_wr  = wr_present_r && (wr_owner_r == s1_req_r);

  rrwl_decide #(
    .DEPTH_W   (DEPTH_W),
    .MAX_DEPTH (MAX_DEPTH)
  ) u_decide (
    .cmd        (s1_cmd_r),
    .req_ok     (req_ok),
    .rd_depth   (rd_cur),
    .total      (total_r),
    .wr_present (wr_present_r),
    .is_wr      (is_wr),
    .wr_depth   (wr_depth_r),
    .status     (status),
    .upd        (upd)
  );

  always_comb begin
    rd_nxt         = rd_cur;
    total_nxt      = total_r;
    wr_present_nxt = wr_present_r;
    wr_owner_nxt   = wr_owner_r;
    wr_depth_nxt   = wr_depth_r;
    if (upd.rd_inc) begin
      rd_nxt    = rd_cur + DEPTH_W'(1);
      total_nxt = total_r + TOTAL_W'(1);
    end
    if (upd.rd_dec) begin
      rd_nxt = rd_cur - DEPTH_W'(1);
    end
    if (upd.tot_dec) begin
      total_nxt = total_r - TOTAL_W'(1);
    end
    if (upd.wr_set) begin
      wr_present_nxt = 1'b1;
      wr_owner_nxt   = s1_req_r;
      wr_depth_nxt   = DEPTH_W'(1);
    end
    if (upd.wr_inc) begin
      wr_depth_nxt = wr_depth_r + DEPTH_W'(1);
    end
    if (upd.wr_dec) begin
      wr_depth_nxt = wr_depth_r - DEPTH_W'(1);
    end
    if (upd.wr_clear) begin
      wr_present_nxt = 1'b0;
      wr_owner_nxt   = '0;
      wr_depth_nxt   = '0;
    end
  end

  // hold report reflects the state after this request
  always_comb begin
    hw_new    = wr_present_nxt && (wr_owner_nxt == s1_req_r);
    hr_new    = (rd_nxt != '0);
    depth_ext = hw_new ? DEPTH_EXT_W'(wr_depth_nxt) : DEPTH_EXT_W'(rd_nxt);
    hold_new  = (depth_ext > HOLD_SAT) ? HOLD_W'(HOLD_SAT) : depth_ext[HOLD_W-1:0];
    if (!req_ok) begin
      hw_new   = 1'b0;
      hr_new   = 1'b0;
      hold_new = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      total_r      <= '0;
      wr_present_r <= 1'b0;
      wr_owner_r   <= '0;
      wr_depth_r   <= '0;
      for (int i = 0; i < STORE_N; i++) begin
        rd_depth_r[i] <= '0;
      end
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (fire) begin
        rd_depth_r[idx] <= rd_nxt;
        total_r         <= total_nxt;
        wr_present_r    <= wr_present_nxt;
        wr_owner_r      <= wr_owner_nxt;
        wr_depth_r      <= wr_depth_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd_r <= in_cmd;
      s1_req_r <= in_requester;
    end
    if (fire) begin
      out_status_r <= status;
      out_hr_r     <= hr_new;
      out_hw_r     <= hw_new;
      out_depth_r  <= hold_new;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_holds_read  = out_hr_r;
  assign out_holds_write = out_hw_r;
  assign out_hold_depth  = out_depth_r;

endmodule

// ===== rtl/rrwl_checker.sv =====
// ----------------------------------------------------------------------------
// rrwl_checker
// Port-level checks on the result channel of the lock manager.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rrwl_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [rrwl_pkg::STATUS_W-1:0] out_status,
  input logic                          out_holds_read,
  input logic                          out_holds_write,
  input logic [rrwl_pkg::HOLD_W-1:0]   out_hold_depth
);
  import rrwl_pkg::*;

  `ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_valid, "result valid after reset")

  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_hold_depth), "stalled result changed")

  // a nonzero depth is reported exactly when some hold is reported
  `ASSERT_CLK(a_depth_holds, out_valid |-> ((out_holds_read || out_holds_write) == (out_hold_depth != '0)), "hold depth disagrees with hold flags")

  // busy only ever refuses a requester that is not the writer
  `ASSERT_CLK(a_busy_not_writer, out_valid && out_status == ST_BUSY |-> !out_holds_write, "busy reported to the writer")

endmodule

bind recursive_reader_writer_lock rrwl_checker u_rrwl_checker (.*);
